FILE: design/sdt_pkg.sv
// ----------------------------------------------------------------------------
// sdt_pkg
// Shared types and codes for the single-level directory table.
// ----------------------------------------------------------------------------
package sdt_pkg;

  // results one list operation may produce
  localparam int MAX_RESULTS = 16;

  // fixed port widths
  localparam int KEY_W    = 64;
  localparam int SLOT_W   = 4;
  localparam int COUNT_W  = 5;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_SEARCH = 2'd2,
    KIND_LIST   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_MOVE = 4'b0100,
    S_LIST = 4'b1000
  } state_t;

endpackage

FILE: design/single_level_directory_table.sv
// ----------------------------------------------------------------------------
// single_level_directory_table
// Flat directory of fixed-width names in a RAM plus an entry count.
// ----------------------------------------------------------------------------
//  channel   ports                                      transfer
//  command   start, busy, in_kind, in_key_name          start && !busy
//  result    out_valid, out_status, out_slot,           out_valid (one cycle,
//            out_entry_name, out_entries_now, out_last  no back pressure)
//
// insert is handled in the idle state, its result shows the cycle after the transfer.
// search walks the RAM one entry a cycle, over at most count entries.
// delete adds one RAM read of the last entry and its write back.
// list gives one result a cycle for min(count, 16) entries, after a first RAM read.
// reset clears the count, state and valid flag only; entries above the count are never used.
// busy is high while a walk is in progress; results never stall.
// ----------------------------------------------------------------------------
module single_level_directory_table #(
  parameter int ENTRIES    = 16,
  parameter int NAME_BYTES = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     in_kind,
  input  logic [sdt_pkg::KEY_W-1:0]      in_key_name,
  output logic                           out_valid,
  output logic [1:0]                     out_status,
  output logic [sdt_pkg::SLOT_W-1:0]     out_slot,
  output logic [sdt_pkg::KEY_W-1:0]      out_entry_name,
  output logic [sdt_pkg::COUNT_W-1:0]    out_entries_now,
  output logic                           out_last
);

  import sdt_pkg::*;

  localparam int NW = 8 * NAME_BYTES;
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  state_t           state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [IW-1:0]    idx_r, idx_nxt;
  logic [NW-1:0]    key_r, key_nxt;
  kind_t            kind_r, kind_nxt;

  logic             valid_r, valid_nxt;
  status_t          status_r, status_nxt;
  logic [SLOT_W-1:0]  slot_r;
  logic [KEY_W-1:0]   name_r, name_nxt;
  logic [COUNT_W-1:0] entries_r;
  logic             last_r, last_nxt;

  logic             ram_we;
  logic [IW-1:0]    ram_waddr, ram_raddr;
  logic [NW-1:0]    ram_wdata, ram_rdata;

  logic [IW-1:0]    idx_p1, slot_sel;
  logic [CW-1:0]    last_idx;
  logic [NW-1:0]    in_key;
  logic             full, empty, hit, scan_end, list_end;
  int               list_n;
  logic [IW+SLOT_W-1:0]  slot_ext;
  logic [CW+COUNT_W-1:0] count_ext;
  logic [KEY_W+NW-1:0]   name_ext;

  sdt_ram #(
    .WIDTH (NW),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_key   = in_key_name[NW-1:0];
  assign idx_p1   = idx_r + IW'(1);
  assign last_idx = count_r - CW'(1);
  assign full     = int'(count_r) >= ENTRIES;
  assign empty    = count_r == '0;
  assign hit      = ram_rdata == key_r;
  assign scan_end = int'(idx_r) + 1 == int'(count_r);
  assign list_n   = (int'(count_r) > MAX_RESULTS) ? MAX_RESULTS : int'(count_r);
  assign list_end = int'(idx_r) + 1 == list_n;
  assign name_ext = {{KEY_W{1'b0}}, ram_rdata};

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    key_nxt    = key_r;
    kind_nxt   = kind_r;
    ram_we     = 1'b0;
    ram_waddr  = count_r[IW-1:0];
    ram_wdata  = in_key;
    ram_raddr  = idx_p1;
    valid_nxt  = 1'b0;
    status_nxt = ST_OK;
    slot_sel   = '0;
    name_nxt   = '0;
    last_nxt   = 1'b1;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          key_nxt  = in_key;
          kind_nxt = kind_t'(in_kind);
          if (kind_t'(in_kind) == KIND_INSERT) begin
            valid_nxt = 1'b1;
            if (full) begin
              status_nxt = ST_FULL;
            end else begin
              ram_we    = 1'b1;
              slot_sel  = count_r[IW-1:0];
              count_nxt = count_r + CW'(1);
            end
          end else if (empty) begin
            valid_nxt  = 1'b1;
            status_nxt = ST_EMPTY;
          end else begin
            ram_raddr = '0;
            idx_nxt   = '0;
            state_nxt = (kind_t'(in_kind) == KIND_LIST) ? S_LIST : S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          if (kind_r == KIND_DELETE) begin
            // fetch the last entry to fill the hole
            ram_raddr = last_idx[IW-1:0];
            state_nxt = S_MOVE;
          end else begin
            valid_nxt = 1'b1;
            slot_sel  = idx_r;
            state_nxt = S_IDLE;
          end
        end else if (scan_end) begin
          valid_nxt  = 1'b1;
          status_nxt = ST_NOT_FOUND;
          state_nxt  = S_IDLE;
        end else begin
          idx_nxt = idx_p1;
        end
      end
      S_MOVE: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r;
        ram_wdata = ram_rdata;
        count_nxt = last_idx;
        valid_nxt = 1'b1;
        slot_sel  = idx_r;
        state_nxt = S_IDLE;
      end
      S_LIST: begin
        valid_nxt = 1'b1;
        slot_sel  = idx_r;
        name_nxt  = name_ext[KEY_W-1:0];
        last_nxt  = list_end;
        if (list_end) begin
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_p1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign slot_ext  = {{SLOT_W{1'b0}}, slot_sel};
  assign count_ext = {{COUNT_W{1'b0}}, count_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    key_r     <= key_nxt;
    kind_r    <= kind_nxt;
    status_r  <= status_nxt;
    slot_r    <= slot_ext[SLOT_W-1:0];
    name_r    <= name_nxt;
    entries_r <= count_ext[COUNT_W-1:0];
    last_r    <= last_nxt;
  end

  assign busy            = state_r != S_IDLE;
  assign out_valid       = valid_r;
  assign out_status      = status_r;
  assign out_slot        = slot_r;
  assign out_entry_name  = name_r;
  assign out_entries_now = entries_r;
  assign out_last        = last_r;

endmodule

FILE: design/sdt_ram.sv
// ----------------------------------------------------------------------------
// sdt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sdt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/sdt_check.sv
// ----------------------------------------------------------------------------
// sdt_check
// Port-level checks for the directory table, bound to the top level.
// ----------------------------------------------------------------------------
module sdt_check (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic [1:0]                  in_kind,
  input logic                        out_valid,
  input logic [1:0]                  out_status,
  input logic [sdt_pkg::COUNT_W-1:0] out_entries_now,
  input logic                        out_last
);

  import sdt_pkg::*;

  // insert always answers in the next cycle with a single result
  a_insert_one: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_kind == KIND_INSERT |=> out_valid && out_last)
    else $error("insert result missing");

  // the final result of an operation leaves the block ready
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> !busy)
    else $error("busy after final result");

  // a list still running keeps the block busy
  a_more_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> busy && out_status == ST_OK)
    else $error("open list without busy");

  // an empty answer reports a zero count
  a_empty_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_EMPTY |-> out_entries_now == '0)
    else $error("empty status with entries");

endmodule

bind single_level_directory_table sdt_check u_sdt_check (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_kind         (in_kind),
  .out_valid       (out_valid),
  .out_status      (out_status),
  .out_entries_now (out_entries_now),
  .out_last        (out_last)
);

FILE: dv/directory_scoreboard_pkg.sv
// ----------------------------------------------------------------------------
// directory_scoreboard_pkg
// Predicts the directory table contents and count for every accepted command
// and checks each result the block gives against the oldest one still due.
// ----------------------------------------------------------------------------
package directory_scoreboard_pkg;
  import sdt_pkg::*;

  localparam int TABLE_ENTRIES = 16;
  localparam int NAME_BYTES    = 8;

  typedef struct packed {
    status_t              status;
    logic [SLOT_W-1:0]    slot;
    logic [KEY_W-1:0]     name;
    logic [COUNT_W-1:0]   entries_now;
    logic                 last;
  } dir_result_t;

  class directory_scoreboard;
    logic [KEY_W-1:0] names [TABLE_ENTRIES];
    int unsigned      count;
    dir_result_t      due_q [$];
    int unsigned      fail_cnt;

    function new();
      count    = 0;
      fail_cnt = 0;
    endfunction

    function logic [KEY_W-1:0] name_mask();
      logic [KEY_W-1:0] m;
      m = '1;
      if (NAME_BYTES < 8) begin
        m = m >> (8 * (8 - NAME_BYTES));
      end
      return m;
    endfunction

    function int unsigned entries();
      return count;
    endfunction

    function int unsigned pending();
      return due_q.size();
    endfunction

    function int unsigned failures();
      return fail_cnt;
    endfunction

    function logic [KEY_W-1:0] stored_name(int unsigned idx);
      return names[idx];
    endfunction

    function void push_result(status_t st, int unsigned slot, logic [KEY_W-1:0] nm,
                              bit last);
      dir_result_t r;
      r.status      = st;
      r.slot        = slot[SLOT_W-1:0];
      r.name        = nm;
      r.entries_now = count[COUNT_W-1:0];
      r.last        = last;
      due_q.push_back(r);
    endfunction

    function int find_name(logic [KEY_W-1:0] key);
      for (int unsigned i = 0; i < count && i < TABLE_ENTRIES; i++) begin
        if (names[i] == key) return int'(i);
      end
      return -1;
    endfunction

    // one accepted command: update the table and queue the results it gives
    function void note_command(kind_t kind, logic [KEY_W-1:0] key_in);
      logic [KEY_W-1:0] key;
      int               hit;
      int unsigned      n;
      key = key_in & name_mask();
      case (kind)
        KIND_INSERT: begin
          if (count >= TABLE_ENTRIES) begin
            push_result(ST_FULL, 0, '0, 1'b1);
          end else begin
            names[count] = key;
            count++;
            push_result(ST_OK, count - 1, '0, 1'b1);
          end
        end
        KIND_DELETE: begin
          if (count == 0) begin
            push_result(ST_EMPTY, 0, '0, 1'b1);
          end else begin
            hit = find_name(key);
            if (hit < 0) begin
              push_result(ST_NOT_FOUND, 0, '0, 1'b1);
            end else begin
              // last entry fills the hole
              names[hit] = names[count - 1];
              count--;
              push_result(ST_OK, hit, '0, 1'b1);
            end
          end
        end
        KIND_SEARCH: begin
          if (count == 0) begin
            push_result(ST_EMPTY, 0, '0, 1'b1);
          end else begin
            hit = find_name(key);
            if (hit < 0) push_result(ST_NOT_FOUND, 0, '0, 1'b1);
            else push_result(ST_OK, hit, '0, 1'b1);
          end
        end
        default: begin
          if (count == 0) begin
            push_result(ST_EMPTY, 0, '0, 1'b1);
          end else begin
            n = count;
            if (n > TABLE_ENTRIES) n = TABLE_ENTRIES;
            if (n > MAX_RESULTS) n = MAX_RESULTS;
            for (int unsigned i = 0; i < n; i++) begin
              push_result(ST_OK, i, names[i], i + 1 == n);
            end
          end
        end
      endcase
    endfunction

    function void check_result(dir_result_t got);
      dir_result_t want;
      if (due_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10) begin
          $display("error: result with nothing due: status %0d slot %0d name %h count %0d last %0b",
                   got.status, got.slot, got.name, got.entries_now, got.last);
        end
        return;
      end
      want = due_q.pop_front();
      if (got.status !== want.status || got.slot !== want.slot || got.name !== want.name ||
          got.entries_now !== want.entries_now || got.last !== want.last) begin
        fail_cnt++;
        if (fail_cnt <= 10) begin
          $display("error: expected status %0d slot %0d name %h count %0d last %0b",
                   want.status, want.slot, want.name, want.entries_now, want.last);
          $display("       got      status %0d slot %0d name %h count %0d last %0b",
                   got.status, got.slot, got.name, got.entries_now, got.last);
        end
      end
    endfunction

    // anything still due at the end never came out
    function void close_out();
      while (due_q.size() != 0) begin
        fail_cnt++;
        if (fail_cnt <= 10) begin
          $display("error: missing result with status %0d slot %0d",
                   due_q[0].status, due_q[0].slot);
        end
        void'(due_q.pop_front());
      end
    endfunction
  endclass

endpackage

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives insert, delete, search and list commands into the directory table,
// directed corner cases first and then random bursts, and checks every
// result against a predicted copy of the table.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sdt_pkg::*;
  import directory_scoreboard_pkg::*;

  logic                 clk         = 1'b0;
  logic                 rst_n       = 1'b0;
  logic                 start       = 1'b0;
  logic [1:0]           in_kind     = KIND_INSERT;
  logic [KEY_W-1:0]     in_key_name = '0;
  logic                 busy;
  logic                 out_valid;
  logic [1:0]           out_status;
  logic [SLOT_W-1:0]    out_slot;
  logic [KEY_W-1:0]     out_entry_name;
  logic [COUNT_W-1:0]   out_entries_now;
  logic                 out_last;

  directory_scoreboard  sb = new();
  logic [KEY_W-1:0]     name_pool [6];

  always #1 clk = ~clk;

  single_level_directory_table #(
    .ENTRIES    (TABLE_ENTRIES),
    .NAME_BYTES (NAME_BYTES)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_kind         (in_kind),
    .in_key_name     (in_key_name),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_slot        (out_slot),
    .out_entry_name  (out_entry_name),
    .out_entries_now (out_entries_now),
    .out_last        (out_last)
  );

  always @(posedge clk) begin
    dir_result_t got;
    if (rst_n && out_valid === 1'b1) begin
      got.status      = status_t'(out_status);
      got.slot        = out_slot;
      got.name        = out_entry_name;
      got.entries_now = out_entries_now;
      got.last        = out_last;
      sb.check_result(got);
    end
  end

  initial begin
    #400000;
    $display("simulation failed");
    $finish;
  end

  function automatic logic [KEY_W-1:0] any_name();
    return {$urandom, $urandom};
  endfunction

  // start stays high across back-to-back transfers
  task automatic issue(kind_t kind, logic [KEY_W-1:0] key);
    @(negedge clk);
    start       <= 1'b1;
    in_kind     <= kind;
    in_key_name <= key;
    do @(posedge clk); while (busy);
    sb.note_command(kind, key);
  endtask

  task automatic pause(int unsigned cycles);
    @(negedge clk);
    start <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned burst_left;
    int unsigned gap;
    int unsigned r;
    int unsigned cnt;
    bit          filling;
    kind_t       kind;
    logic [KEY_W-1:0] key;

    foreach (name_pool[i]) name_pool[i] = any_name();
    name_pool[0] = '1;
    name_pool[1] = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // empty table answers, then inserts with a duplicate, a hit and two misses
    issue(KIND_LIST, '0);
    issue(KIND_DELETE, 64'h0123_4567_89ab_cdef);
    issue(KIND_SEARCH, '1);
    issue(KIND_INSERT, '1);
    issue(KIND_INSERT, '0);
    issue(KIND_INSERT, '1);
    issue(KIND_SEARCH, '1);
    issue(KIND_SEARCH, 64'h5555_5555_5555_5555);
    issue(KIND_DELETE, 64'haaaa_aaaa_aaaa_aaaa);
    // first of the duplicates goes, last entry moves into slot 0
    issue(KIND_DELETE, '1);
    issue(KIND_LIST, '0);
    for (int i = 0; i < 14; i++) begin
      issue(KIND_INSERT, (i % 2) ? any_name() : (64'd1 << (i * 4 + 3)));
    end
    issue(KIND_INSERT, 64'h8000_0000_0000_0001);
    issue(KIND_LIST, '0);
    drain();

    burst_left = 0;
    filling    = 1'b0;
    for (int n = 0; n < 280; n++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap = $urandom_range(0, 7);
        if (gap != 0) pause(gap);
      end
      burst_left--;
      if (n == 140) drain();

      cnt = sb.entries();
      if (cnt == TABLE_ENTRIES) filling = 1'b0;
      else if (cnt == 0) filling = 1'b1;
      else if ($urandom_range(0, 29) == 0) filling = !filling;

      r = $urandom_range(0, 99);
      if (filling) begin
        kind = (r < 55) ? KIND_INSERT : (r < 70) ? KIND_DELETE :
               (r < 88) ? KIND_SEARCH : KIND_LIST;
      end else begin
        kind = (r < 20) ? KIND_INSERT : (r < 65) ? KIND_DELETE :
               (r < 85) ? KIND_SEARCH : KIND_LIST;
      end

      r = $urandom_range(0, 99);
      if (kind == KIND_INSERT) begin
        key = (r < 40) ? name_pool[$urandom_range(0, 5)] : any_name();
      end else if (r < 70 && cnt != 0) begin
        key = sb.stored_name($urandom_range(0, cnt - 1));
      end else if (r < 85) begin
        key = name_pool[$urandom_range(0, 5)];
      end else begin
        key = any_name();
      end
      issue(kind, key);
    end

    drain();
    repeat (40) @(posedge clk);
    sb.close_out();
    if (sb.failures() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: files.f
design/sdt_pkg.sv
design/sdt_ram.sv
design/single_level_directory_table.sv
design/sdt_check.sv
dv/directory_scoreboard_pkg.sv
dv/testbench.sv
